// ===== rtl/core/lci_pkg.sv =====
// ----------------------------------------------------------------------------
// lci_pkg
// Shared types and constants for the launch countdown interlock.
// ----------------------------------------------------------------------------
package lci_pkg;

    localparam int unsigned AGE_W   = 10;
    localparam int unsigned PRES_W  = 10;
    localparam int unsigned ACC_W   = 16;
    localparam int unsigned COUNT_W = 8;

    localparam logic [AGE_W-1:0] AGE_MAX = '1;

    // configuration register indexes
    localparam logic [1:0] CFG_PRESS_TRIP      = 2'd0;
    localparam logic [1:0] CFG_DEBOUNCE_TICKS  = 2'd1;
    localparam logic [1:0] CFG_TICKS_PER_COUNT = 2'd2;
    localparam logic [1:0] CFG_COUNTDOWN_START = 2'd3;

    // configuration reset values
    localparam logic [PRES_W-1:0]  RST_PRESS_TRIP      = 10'd800;
    localparam logic [AGE_W-1:0]   RST_DEBOUNCE_TICKS  = 10'd50;
    localparam logic [ACC_W-1:0]   RST_TICKS_PER_COUNT = 16'd1000;
    localparam logic [COUNT_W-1:0] RST_COUNTDOWN_START = 8'd10;

    typedef enum logic [1:0] {
        PH_SAFE  = 2'd0,
        PH_COUNT = 2'd1,
        PH_READY = 2'd2,
        PH_ABORT = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_START = 2'd1,
        CMD_ABORT = 2'd2,
        CMD_RESET = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_NONE         = 3'd0,
        ST_ACCEPTED     = 3'd1,
        ST_DENY_LATCHED = 3'd2,
        ST_DENY_STATE   = 3'd3,
        ST_DENY_BUTTON  = 3'd4,
        ST_DENY_PRESS   = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        CAUSE_NONE     = 2'd0,
        CAUSE_BUTTON   = 2'd1,
        CAUSE_PRESSURE = 2'd2
    } t_cause;

    typedef struct packed {
        logic [PRES_W-1:0]  press_trip;
        logic [AGE_W-1:0]   debounce_ticks;
        logic [ACC_W-1:0]   ticks_per_count;
        logic [COUNT_W-1:0] countdown_start;
    } t_cfg;

    typedef struct packed {
        logic             raw;
        logic             stable;
        logic [AGE_W-1:0] age;
    } t_deb;

    typedef struct packed {
        t_cmd              cmd;
        logic              start_level;
        logic              emergency_level;
        logic [PRES_W-1:0] pressure;
    } t_item;

    typedef struct packed {
        t_phase             phase;
        logic [COUNT_W-1:0] count_now;
        logic               led_one;
        logic               led_two;
        logic               abort_latched;
        t_status            cmd_status;
        t_cause             abort_cause;
    } t_result;

endpackage

// ===== rtl/core/lci_debounce.sv =====
// ----------------------------------------------------------------------------
// lci_debounce
// Next-state logic of one button debouncer, flags a stable press.
// ----------------------------------------------------------------------------
module lci_debounce
    import lci_pkg::*;
(
    input  logic             i_level,
    input  t_deb             i_state,
    input  logic [AGE_W-1:0] i_debounce_ticks,
    output t_deb             o_state,
    output logic             o_press
);

    always_comb begin
        o_state = i_state;
        o_press = 1'b0;
        if (i_level != i_state.raw) begin
            o_state.raw = i_level;
            o_state.age = '0;
        end else if (i_state.age != AGE_MAX) begin
            o_state.age = i_state.age + 1'b1;
        end
        // accept the raw level once it has held long enough
        if ((o_state.age >= i_debounce_ticks) && (o_state.stable != o_state.raw)) begin
            o_state.stable = o_state.raw;
            o_press        = ~o_state.raw;
        end
    end

endmodule

// ===== rtl/core/lci_step.sv =====
// ----------------------------------------------------------------------------
// lci_step
// Interlock state registers and the per-tick update of one word.
// ----------------------------------------------------------------------------
module lci_step
    import lci_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  t_cfg    i_cfg,
    input  t_item   i_item,
    output t_result o_result
);

    t_phase             r_phase, n_phase;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [ACC_W-1:0]   r_accum, n_accum;
    logic               r_latch, n_latch;
    logic [1:0]         r_led,   n_led;
    t_deb               r_start, n_start;
    t_deb               r_emerg, n_emerg;

    t_deb               emerg_upd, start_upd;
    logic               emerg_press, start_press;
    t_phase             phase_before;
    logic               entered;
    logic [ACC_W-1:0]   period;
    logic [ACC_W-1:0]   accum_inc;
    logic [COUNT_W-1:0] count_dec;
    logic               pres_high;
    t_status            status;
    t_cause             cause;

    lci_debounce u_emerg_deb (
        .i_level          (i_item.emergency_level),
        .i_state          (r_emerg),
        .i_debounce_ticks (i_cfg.debounce_ticks),
        .o_state          (emerg_upd),
        .o_press          (emerg_press)
    );

    lci_debounce u_start_deb (
        .i_level          (i_item.start_level),
        .i_state          (r_start),
        .i_debounce_ticks (i_cfg.debounce_ticks),
        .o_state          (start_upd),
        .o_press          (start_press)
    );

    assign period    = (i_cfg.ticks_per_count == '0) ? ACC_W'(1) : i_cfg.ticks_per_count;
    assign pres_high = (i_item.pressure >= i_cfg.press_trip);

    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_accum   = r_accum;
        n_latch   = r_latch;
        n_led     = r_led;
        n_start   = r_start;
        n_emerg   = emerg_upd;
        status    = ST_NONE;
        cause     = CAUSE_NONE;
        entered   = 1'b0;
        accum_inc = r_accum + 1'b1;
        count_dec = r_count;

        // emergency press latches an abort
        if (emerg_press && !r_latch) begin
            n_latch = 1'b1;
            cause   = CAUSE_BUTTON;
            n_phase = PH_ABORT;
            n_led   = 2'b00;
        end
        phase_before = n_phase;

        // start button is only watched outside abort
        if (phase_before != PH_ABORT) begin
            n_start = start_upd;
            if (start_press && !n_latch && (n_phase == PH_SAFE)) begin
                n_phase = PH_COUNT;
                n_count = i_cfg.countdown_start;
                n_accum = '0;
                n_led   = 2'b01;
            end
        end

        unique case (i_item.cmd)
            CMD_NONE: begin
                status = ST_NONE;
            end
            CMD_START: begin
                if (n_latch) begin
                    status = ST_DENY_LATCHED;
                end else if (n_phase != PH_SAFE) begin
                    status = ST_DENY_STATE;
                end else begin
                    n_phase = PH_COUNT;
                    n_count = i_cfg.countdown_start;
                    n_accum = '0;
                    n_led   = 2'b01;
                    status  = ST_ACCEPTED;
                end
            end
            CMD_ABORT: begin
                if (n_latch) begin
                    status = ST_DENY_LATCHED;
                end else begin
                    n_latch = 1'b1;
                    cause   = CAUSE_BUTTON;
                    n_phase = PH_ABORT;
                    n_led   = 2'b00;
                    status  = ST_ACCEPTED;
                end
            end
            CMD_RESET: begin
                if (!i_item.emergency_level) begin
                    status = ST_DENY_BUTTON;
                end else if (pres_high) begin
                    status = ST_DENY_PRESS;
                end else begin
                    n_latch = 1'b0;
                    n_start = '{raw: i_item.start_level, stable: i_item.start_level,
                                age: '0};
                    n_emerg = '{raw: i_item.emergency_level,
                                stable: i_item.emergency_level, age: '0};
                    n_phase = PH_SAFE;
                    n_count = i_cfg.countdown_start;
                    n_accum = '0;
                    n_led   = 2'b00;
                    status  = ST_ACCEPTED;
                end
            end
            default: begin
                status = ST_NONE;
            end
        endcase

        if (phase_before != PH_ABORT) begin
            entered = (phase_before != PH_COUNT) && (n_phase == PH_COUNT);
            // overpressure during countdown
            if ((n_phase == PH_COUNT) && pres_high && !n_latch) begin
                n_latch = 1'b1;
                cause   = CAUSE_PRESSURE;
                n_phase = PH_ABORT;
                n_led   = 2'b00;
            end
            // advance the countdown
            if ((n_phase == PH_COUNT) && !entered) begin
                accum_inc = n_accum + 1'b1;
                if (accum_inc >= period) begin
                    n_accum   = accum_inc - period;
                    count_dec = (n_count != '0) ? n_count - 1'b1 : n_count;
                    n_count   = count_dec;
                    if (count_dec != '0) begin
                        n_led = count_dec[0] ? 2'b10 : 2'b01;
                    end else begin
                        n_phase = PH_READY;
                        n_led   = 2'b00;
                    end
                end else begin
                    n_accum = accum_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SAFE;
            r_count <= RST_COUNTDOWN_START;
            r_accum <= '0;
            r_latch <= 1'b0;
            r_led   <= 2'b00;
            r_start <= '{raw: 1'b1, stable: 1'b1, age: '0};
            r_emerg <= '{raw: 1'b1, stable: 1'b1, age: '0};
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_accum <= n_accum;
            r_latch <= n_latch;
            r_led   <= n_led;
            r_start <= n_start;
            r_emerg <= n_emerg;
        end
    end

    assign o_result = '{phase: n_phase, count_now: n_count, led_one: n_led[0],
                        led_two: n_led[1], abort_latched: n_latch,
                        cmd_status: status, abort_cause: cause};

endmodule

// ===== rtl/core/launch_countdown_interlock.sv =====
// ----------------------------------------------------------------------------
// launch_countdown_interlock
// Countdown and abort interlock with debounced buttons and pressure guard.
// ----------------------------------------------------------------------------
// Path: a word accepted into the input register is updated into the result
//   register on advance and can be taken from there, when not stalled.
// Throughput: one word per cycle when not stalled; the state update sets the pace.
// Reset: synchronous, active low; phase SAFE, count 10, latch clear, both
//   buttons released, configuration back to its default values.
module launch_countdown_interlock
    import lci_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] cmd, [2] start_level, [3] emergency_level, [13:4] pressure,
    // [15:14] zero
    input  logic [15:0] s_axis_tdata,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] phase, [9:2] count_now, [10] led_one, [11] led_two,
    // [12] abort_latched, [15:13] cmd_status, [17:16] abort_cause, [23:18] zero
    output logic [23:0] m_axis_tdata,
    // configuration write port
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // configuration registers
    t_cfg    r_cfg;

    // input register
    logic    r_in_vld;
    t_item   r_in;

    // result register
    logic    r_out_vld;
    t_result r_out;

    t_result step_result;
    logic    adv;

    // Advance the input word into the state update when the result register
    // is free or being drained this cycle.
    assign adv           = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_trip      <= RST_PRESS_TRIP;
            r_cfg.debounce_ticks  <= RST_DEBOUNCE_TICKS;
            r_cfg.ticks_per_count <= RST_TICKS_PER_COUNT;
            r_cfg.countdown_start <= RST_COUNTDOWN_START;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_PRESS_TRIP:      r_cfg.press_trip      <= i_cfg_data[PRES_W-1:0];
                CFG_DEBOUNCE_TICKS:  r_cfg.debounce_ticks  <= i_cfg_data[AGE_W-1:0];
                CFG_TICKS_PER_COUNT: r_cfg.ticks_per_count <= i_cfg_data[ACC_W-1:0];
                CFG_COUNTDOWN_START: r_cfg.countdown_start <= i_cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Hold the input word until the update stage takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.cmd             <= t_cmd'(s_axis_tdata[1:0]);
            r_in.start_level     <= s_axis_tdata[2];
            r_in.emergency_level <= s_axis_tdata[3];
            r_in.pressure        <= s_axis_tdata[13:4];
        end
    end

    // State registers and the tick update; state commits only on advance.
    lci_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_cfg    (r_cfg),
        .i_item   (r_in),
        .o_result (step_result)
    );

    // Result register: load on advance, drop valid once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= step_result;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {6'd0, r_out.abort_cause, r_out.cmd_status,
                            r_out.abort_latched, r_out.led_two, r_out.led_one,
                            r_out.count_now, r_out.phase};

    // An aborted phase always carries the latch.
    a_abort_latched : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out.phase == PH_ABORT)) |-> r_out.abort_latched)
        else $error("aborted phase without latch");

    // Exactly one lamp is lit while counting down.
    a_led_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out.phase == PH_COUNT)) |-> $onehot({r_out.led_two, r_out.led_one}))
        else $error("countdown lamp pattern broken");

    // Lamps are dark outside countdown.
    a_led_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out.phase != PH_COUNT)) |-> !(r_out.led_one || r_out.led_two))
        else $error("lamp lit outside countdown");

    // READY is reached only with the count run out.
    a_ready_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out.phase == PH_READY)) |-> (r_out.count_now == '0))
        else $error("ready with nonzero count");

endmodule
